// ===== design/double_ended_queue_top_assert.svh =====
// Assertion macros for the double-ended queue checker.
// Included by name from the checker file; defines only macros.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DEQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DEQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ===== design/deq_pkg.sv =====
// Shared codes and types for the double-ended queue.
// No dependencies; used by the cells, the top level and the checker.
`default_nettype none
package deq_pkg;

	localparam logic [1:0] KIND_PUSH_RIGHT = 2'd0;
	localparam logic [1:0] KIND_POP_LEFT   = 2'd1;
	localparam logic [1:0] KIND_POP_RIGHT  = 2'd2;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	// Per-row cell control; shift_dn takes the upper neighbor, shift_up the lower.
	typedef struct packed {
		logic load;
		logic shift_dn;
		logic shift_up;
	} deq_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/deq_if.sv =====
// Request and response channel interfaces for the double-ended queue.
// Valid/ready handshake; widths follow the item width and count width.
`default_nettype none
interface deq_req_if #(
	parameter int ITEM_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic [ITEM_WIDTH-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if #(
	parameter int ITEM_WIDTH = 32,
	parameter int CNT_W      = 5
);
	logic                  valid;
	logic                  ready;
	logic [ITEM_WIDTH-1:0] popped_value;
	logic                  pop_valid;
	logic [1:0]            error_code;
	logic [ITEM_WIDTH-1:0] left_item;
	logic [ITEM_WIDTH-1:0] right_item;
	logic [CNT_W-1:0]      item_count;
	logic                  is_empty;

	modport source (output valid, output popped_value, output pop_valid, output error_code,
		output left_item, output right_item, output item_count, output is_empty,
		input ready);
	modport sink   (input valid, input popped_value, input pop_valid, input error_code,
		input left_item, input right_item, input item_count, input is_empty,
		output ready);
endinterface
`default_nettype wire

// ===== design/double_ended_queue_top.sv =====
// Bounded double-ended queue built from two rows of shifting cells.
// Depends on deq_pkg, deq_if, deq_chain and deq_cell.
//
// Use:
//   req carries one request: kind (push right, pop left, pop right) and value.
//   rsp returns one result per request: popped value, pop_valid, error code,
//   leftmost and rightmost items, item count and empty flag.
//   One row keeps the leftmost item in cell 0, the other keeps the rightmost
//   item in cell 0; each accepted push or pop shifts or loads the rows.
//   The result is registered and valid the cycle after the request is accepted.
//   Throughput: one request per cycle while rsp takes each result, set by
//   the one-entry output register.
//   A push while full or a pop while empty changes nothing and reports an
//   error; kind 3 changes nothing and reports the current state.
//   Reset empties the queue and drops any pending result; stored items are
//   not cleared.
//   When rsp stalls, the result holds and req.ready drops until it is taken.
`default_nettype none
module double_ended_queue_top #(
	parameter int CAPACITY   = 16,
	parameter int ITEM_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [ITEM_WIDTH-1:0] popped_q;
	logic                  pop_valid_q;
	logic [1:0]            err_q;
	logic [ITEM_WIDTH-1:0] left_q;
	logic [ITEM_WIDTH-1:0] right_q;
	logic [CNT_W-1:0]      count_out_q;

	logic                  fire;
	logic                  is_push;
	logic                  is_pop_l;
	logic                  is_pop_r;
	logic                  full;
	logic                  empty;
	logic                  multi;
	logic                  push_ok;
	logic                  pop_l_ok;
	logic                  pop_r_ok;
	logic [CNT_W-1:0]      count_d;
	logic [ITEM_WIDTH-1:0] popped_d;
	logic [1:0]            err_d;
	logic [ITEM_WIDTH-1:0] left_d;
	logic [ITEM_WIDTH-1:0] right_d;

	logic [ITEM_WIDTH-1:0] l_head;
	logic [ITEM_WIDTH-1:0] l_next;
	logic [ITEM_WIDTH-1:0] r_head;
	logic [ITEM_WIDTH-1:0] r_next;

	deq_pkg::deq_cell_ctrl_t l_ctrl;
	deq_pkg::deq_cell_ctrl_t r_ctrl;

	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	assign is_push  = req.kind == deq_pkg::KIND_PUSH_RIGHT;
	assign is_pop_l = req.kind == deq_pkg::KIND_POP_LEFT;
	assign is_pop_r = req.kind == deq_pkg::KIND_POP_RIGHT;
	assign full     = count_q == CNT_W'(CAPACITY);
	assign empty    = count_q == '0;
	assign multi    = count_q > CNT_W'(1);

	assign push_ok  = is_push && !full;
	assign pop_l_ok = is_pop_l && !empty;
	assign pop_r_ok = is_pop_r && !empty;

	// Left-aligned row: far-end load on push, shift down on left pop.
	assign l_ctrl.load     = fire && push_ok;
	assign l_ctrl.shift_dn = fire && pop_l_ok;
	assign l_ctrl.shift_up = 1'b0;
	// Right-aligned row: shift up on push, shift down on right pop.
	assign r_ctrl.load     = 1'b0;
	assign r_ctrl.shift_dn = fire && pop_r_ok;
	assign r_ctrl.shift_up = fire && push_ok;

	deq_chain #(
		.WIDTH(ITEM_WIDTH),
		.DEPTH(CAPACITY),
		.CNT_W(CNT_W)
	) u_left_row (
		.clk  (clk),
		.ctrl (l_ctrl),
		.count(count_q),
		.value(req.value),
		.head (l_head),
		.next (l_next)
	);

	deq_chain #(
		.WIDTH(ITEM_WIDTH),
		.DEPTH(CAPACITY),
		.CNT_W(CNT_W)
	) u_right_row (
		.clk  (clk),
		.ctrl (r_ctrl),
		.count(count_q),
		.value(req.value),
		.head (r_head),
		.next (r_next)
	);

	always_comb begin
		count_d  = count_q;
		popped_d = '0;
		err_d    = deq_pkg::ERR_OK;
		left_d   = empty ? '0 : l_head;
		right_d  = empty ? '0 : r_head;
		if (is_push) begin
			if (full) begin
				err_d = deq_pkg::ERR_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
				left_d  = empty ? req.value : l_head;
				right_d = req.value;
			end
		end else if (is_pop_l || is_pop_r) begin
			if (empty) begin
				err_d = deq_pkg::ERR_EMPTY;
			end else begin
				count_d  = count_q - CNT_W'(1);
				popped_d = is_pop_l ? l_head : r_head;
				left_d   = !multi ? '0 : (is_pop_l ? l_next : l_head);
				right_d  = !multi ? '0 : (is_pop_r ? r_next : r_head);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			popped_q    <= popped_d;
			pop_valid_q <= pop_l_ok || pop_r_ok;
			err_q       <= err_d;
			left_q      <= left_d;
			right_q     <= right_d;
			count_out_q <= count_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.pop_valid    = pop_valid_q;
	assign rsp.error_code   = err_q;
	assign rsp.left_item    = left_q;
	assign rsp.right_item   = right_q;
	assign rsp.item_count   = count_out_q;
	assign rsp.is_empty     = count_out_q == '0;
endmodule
`default_nettype wire

// ===== design/deq_cell.sv =====
// One storage cell of a deque row: hold, take a neighbor, or load the new item.
// Depends on deq_pkg for the control struct.
`default_nettype none
module deq_cell #(
	parameter int WIDTH = 32,
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  wire logic                    clk,
	input  wire deq_pkg::deq_cell_ctrl_t ctrl,
	input  wire logic [CNT_W-1:0]        count,
	input  wire logic [WIDTH-1:0]        value,
	input  wire logic [WIDTH-1:0]        lower,
	input  wire logic [WIDTH-1:0]        upper,
	output logic      [WIDTH-1:0]        data
);
	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_dn) begin
			data_q <= upper;
		end else if (ctrl.shift_up) begin
			data_q <= lower;
		end else if (ctrl.load && count == CNT_W'(INDEX)) begin
			data_q <= value;
		end
	end

	assign data = data_q;
endmodule
`default_nettype wire

// ===== design/deq_chain.sv =====
// A row of deq_cell instances, cell 0 at the aligned end of the row.
// Depends on deq_pkg and deq_cell.
`default_nettype none
module deq_chain #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  wire logic                    clk,
	input  wire deq_pkg::deq_cell_ctrl_t ctrl,
	input  wire logic [CNT_W-1:0]        count,
	input  wire logic [WIDTH-1:0]        value,
	output logic      [WIDTH-1:0]        head,
	output logic      [WIDTH-1:0]        next
);
	logic [WIDTH-1:0] cells [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] lower;
		logic [WIDTH-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = value;
		end else begin : g_inner_lo
			assign lower = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = cells[i];
		end else begin : g_inner_hi
			assign upper = cells[i+1];
		end

		deq_cell #(
			.WIDTH(WIDTH),
			.INDEX(i),
			.CNT_W(CNT_W)
		) u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.count(count),
			.value(value),
			.lower(lower),
			.upper(upper),
			.data (cells[i])
		);
	end

	assign head = cells[0];
	assign next = cells[1];
endmodule
`default_nettype wire

// ===== design/deq_checker.sv =====
// Port-level checks on the deque response channel, bound to the top level.
// Depends on deq_pkg and double_ended_queue_top_assert.svh.
`default_nettype none
`include "double_ended_queue_top_assert.svh"
module deq_checker #(
	parameter int ITEM_WIDTH = 32,
	parameter int CNT_W      = 5
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  rsp_valid,
	input wire logic                  rsp_ready,
	input wire logic [ITEM_WIDTH-1:0] popped_value,
	input wire logic                  pop_valid,
	input wire logic [1:0]            error_code,
	input wire logic [ITEM_WIDTH-1:0] left_item,
	input wire logic [ITEM_WIDTH-1:0] right_item,
	input wire logic [CNT_W-1:0]      item_count,
	input wire logic                  is_empty
);
	`DEQ_ASSERT_IMP(a_empty_peeks, rsp_valid && is_empty,
		item_count == '0 && left_item == '0 && right_item == '0)
	`DEQ_ASSERT_IMP(a_no_pop_zero, rsp_valid && !pop_valid, popped_value == '0)
	`DEQ_ASSERT_IMP(a_pop_ok, rsp_valid && pop_valid, error_code == deq_pkg::ERR_OK)
	`DEQ_ASSERT_NXT(a_hold_valid, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind double_ended_queue_top deq_checker #(
	.ITEM_WIDTH(ITEM_WIDTH),
	.CNT_W     ($clog2(CAPACITY + 1))
) u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.popped_value(rsp.popped_value),
	.pop_valid   (rsp.pop_valid),
	.error_code  (rsp.error_code),
	.left_item   (rsp.left_item),
	.right_item  (rsp.right_item),
	.item_count  (rsp.item_count),
	.is_empty    (rsp.is_empty)
);
`default_nettype wire
